FILE: src/mahs_pkg.sv
// Shared types, constants and lookup tables for the MPEG audio header scanner.
// Used by the decode, divider and top-level modules; no dependencies.
package mahs_pkg;

	localparam int NUM_W = 26;  // 144 * 448 * 1000 fits in 26 bits
	localparam int SR_W  = 16;
	localparam int BR_W  = 9;
	localparam int SPF_W = 11;
	localparam int LEN_W = 12;
	localparam int K_W   = 18;  // widest frame-length coefficient, 144000

	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [2:0] SYNC_TOP  = 3'b111;

	localparam logic [1:0] VER_MPEG25 = 2'd0;
	localparam logic [1:0] VER_RSVD   = 2'd1;
	localparam logic [1:0] VER_MPEG2  = 2'd2;
	localparam logic [1:0] VER_MPEG1  = 2'd3;

	localparam logic [1:0] LAYER_RSVD = 2'd0;
	localparam logic [1:0] SRI_RSVD   = 2'd3;
	localparam logic [3:0] BRI_FREE   = 4'd0;
	localparam logic [3:0] BRI_BAD    = 4'd15;
	localparam logic [1:0] MODE_MONO  = 2'd3;

	localparam logic [1:0] LI_ONE   = 2'd0;
	localparam logic [1:0] LI_TWO   = 2'd1;
	localparam logic [1:0] LI_THREE = 2'd2;

	localparam logic [K_W-1:0] K_LAYER1 = K_W'(12 * 1000);
	localparam logic [K_W-1:0] K_HALF   = K_W'(72 * 1000);
	localparam logic [K_W-1:0] K_FULL   = K_W'(144 * 1000);

	localparam logic [BR_W-1:0] KBPS_V1_L1 [16] = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128,
		9'd160, 9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
	localparam logic [BR_W-1:0] KBPS_V1_L2 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64,
		9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
	localparam logic [BR_W-1:0] KBPS_V1_L3 [16] = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56,
		9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
	localparam logic [BR_W-1:0] KBPS_V2_L1 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64,
		9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
	localparam logic [BR_W-1:0] KBPS_V2_L23 [16] = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32,
		9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

	// Decoded header fields handed from the decoder to the top level.
	typedef struct packed {
		logic              ok;
		logic [SR_W-1:0]   sample_rate;
		logic [1:0]        channel_count;
		logic [BR_W-1:0]   bitrate;
		logic [SPF_W-1:0]  spf;
		logic              pad;
		logic              layer1;
		logic [NUM_W-1:0]  numer;
	} hdr_info_t;

	function automatic logic [SR_W-1:0] rate_lookup(input logic [1:0] ver,
			input logic [1:0] sri);
		logic [SR_W-1:0] r;
		r = '0;
		case ({ver, sri})
			{VER_MPEG1, 2'd0}:  r = 16'd44100;
			{VER_MPEG1, 2'd1}:  r = 16'd48000;
			{VER_MPEG1, 2'd2}:  r = 16'd32000;
			{VER_MPEG2, 2'd0}:  r = 16'd22050;
			{VER_MPEG2, 2'd1}:  r = 16'd24000;
			{VER_MPEG2, 2'd2}:  r = 16'd16000;
			{VER_MPEG25, 2'd0}: r = 16'd11025;
			{VER_MPEG25, 2'd1}: r = 16'd12000;
			{VER_MPEG25, 2'd2}: r = 16'd8000;
			default:            r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [BR_W-1:0] kbps_lookup(input logic vg, input logic [1:0] li,
			input logic [3:0] bri);
		logic [BR_W-1:0] b;
		b = '0;
		case ({vg, li})
			{1'b0, LI_ONE}:   b = KBPS_V1_L1[bri];
			{1'b0, LI_TWO}:   b = KBPS_V1_L2[bri];
			{1'b0, LI_THREE}: b = KBPS_V1_L3[bri];
			{1'b1, LI_ONE}:   b = KBPS_V2_L1[bri];
			{1'b1, LI_TWO}:   b = KBPS_V2_L23[bri];
			{1'b1, LI_THREE}: b = KBPS_V2_L23[bri];
			default:          b = '0;
		endcase
		return b;
	endfunction

endpackage

FILE: src/mahs_if.sv
// Valid/ready channel interfaces for the MPEG audio header scanner.
// Depends on mahs_pkg for field widths.
interface mahs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface mahs_result_if;
	logic                        valid;
	logic                        ready;
	logic                        found;
	logic [mahs_pkg::SR_W-1:0]   sample_rate;
	logic [1:0]                  channel_count;
	logic [mahs_pkg::BR_W-1:0]   bitrate_kbps;
	logic [mahs_pkg::SPF_W-1:0]  samples_per_frame;
	logic [mahs_pkg::LEN_W-1:0]  frame_length_bytes;

	modport source (output valid, found, sample_rate, channel_count, bitrate_kbps,
		samples_per_frame, frame_length_bytes, input ready);
	modport sink (input valid, found, sample_rate, channel_count, bitrate_kbps,
		samples_per_frame, frame_length_bytes, output ready);
endinterface

FILE: src/mpeg_audio_header_scanner_core.sv
// Usage notes
// The byte_ch sink takes one buffer byte per item, with last_byte marking the
// final byte. The result_ch source gives at most one item per buffer: the first
// valid MPEG audio frame header (found = 1 with its decoded fields), or, when the
// last byte arrives with no header, a not-found item with every field zero.
// Bytes that yield no result stream at one per cycle while no division runs.
// A byte that completes a valid header starts the frame-length division, which
// runs in a restoring divider producing one quotient bit per cycle; the block
// is not ready while it runs, and the result item is registered when the divider
// reports done. A not-found result appears the cycle after the last
// byte. The result sits in an output register; while it waits, bytes are taken
// only in the cycle it is taken, so a stalled receiver stalls the byte channel.
// After a header, later bytes are ignored until the last byte clears the state.
// Reset clears the state, the byte window, the byte count, the header flag and the output valid flag.
// Depends on mahs_pkg, mahs_if, mahs_decode and mahs_divider.
module mpeg_audio_header_scanner_core (
	input  logic          clk,
	input  logic          arst_n,
	mahs_byte_if.sink     byte_ch,
	mahs_result_if.source result_ch
);
	import mahs_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic             st_q;
	logic [23:0]      window_q;
	logic [1:0]       seen_q;
	logic             hdr_done_q;
	logic             ovalid_q;
	logic             found_q;
	logic [SR_W-1:0]  sr_q;
	logic [1:0]       ch_q;
	logic [BR_W-1:0]  br_q;
	logic [SPF_W-1:0] spf_q;
	logic [LEN_W-1:0] len_q;
	logic             pad_q;
	logic             l1_q;

	hdr_info_t        info;
	logic             acc;
	logic             hit;
	logic             div_done;
	logic [NUM_W-1:0] quot;
	logic [LEN_W-1:0] len_sum;
	logic [LEN_W-1:0] len_val;

	mahs_decode u_decode (
		.hdr  ({window_q, byte_ch.data_byte}),
		.info (info)
	);

	mahs_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (acc && hit),
		.numer  (info.numer),
		.denom  (info.sample_rate),
		.done   (div_done),
		.quot   (quot)
	);

	assign byte_ch.ready = (st_q == ST_IDLE) && (!ovalid_q || result_ch.ready);
	assign acc = byte_ch.valid && byte_ch.ready;
	assign hit = !hdr_done_q && (seen_q == 2'd3) && info.ok;

	// Layer I counts four-byte slots, so padding is added before scaling.
	assign len_sum = quot[LEN_W-1:0] + {{(LEN_W-1){1'b0}}, pad_q};
	assign len_val = l1_q ? {len_sum[LEN_W-3:0], 2'b00} : len_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			window_q   <= '0;
			seen_q     <= '0;
			hdr_done_q <= 1'b0;
			ovalid_q   <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (acc && hit) begin
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase

			if (acc) begin
				if (!hdr_done_q) begin
					window_q <= {window_q[15:0], byte_ch.data_byte};
					if (seen_q != 2'd3) begin
						seen_q <= seen_q + 2'd1;
					end
					if (hit) begin
						hdr_done_q <= 1'b1;
					end
				end
				if (byte_ch.last_byte) begin
					window_q   <= '0;
					seen_q     <= '0;
					hdr_done_q <= 1'b0;
				end
			end

			if (div_done || (acc && byte_ch.last_byte && !hdr_done_q && !hit)) begin
				ovalid_q <= 1'b1;
			end else if (result_ch.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && hit) begin
			sr_q  <= info.sample_rate;
			ch_q  <= info.channel_count;
			br_q  <= info.bitrate;
			spf_q <= info.spf;
			pad_q <= info.pad;
			l1_q  <= info.layer1;
		end
		if (div_done) begin
			found_q <= 1'b1;
			len_q   <= len_val;
		end else if (acc && byte_ch.last_byte && !hdr_done_q && !hit) begin
			found_q <= 1'b0;
			sr_q    <= '0;
			ch_q    <= '0;
			br_q    <= '0;
			spf_q   <= '0;
			len_q   <= '0;
		end
	end

	assign result_ch.valid              = ovalid_q;
	assign result_ch.found              = found_q;
	assign result_ch.sample_rate        = sr_q;
	assign result_ch.channel_count      = ch_q;
	assign result_ch.bitrate_kbps       = br_q;
	assign result_ch.samples_per_frame  = spf_q;
	assign result_ch.frame_length_bytes = len_q;

`ifndef SYNTHESIS
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DIV |-> !byte_ch.ready)
		else $error("byte channel ready while the divider is running");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> st_q == ST_DIV)
		else $error("divider finished outside of the divide state");

	a_header_after_window: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_done_q |-> seen_q == 2'd3)
		else $error("header flagged before four bytes were seen");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && !result_ch.found |-> result_ch.sample_rate == '0
			&& result_ch.bitrate_kbps == '0 && result_ch.frame_length_bytes == '0)
		else $error("not-found item carries nonzero fields");
`endif

endmodule

FILE: src/mahs_decode.sv
// Header qualifier and field decoder for a four-byte window.
// Depends on mahs_pkg for tables and the hdr_info_t type.
module mahs_decode (
	input  logic [31:0]          hdr,
	output mahs_pkg::hdr_info_t  info
);
	import mahs_pkg::*;

	logic [1:0]       ver;
	logic [1:0]       layer;
	logic [3:0]       bri;
	logic [1:0]       sri;
	logic [1:0]       li;
	logic             vg;
	logic [SR_W-1:0]  sr;
	logic [BR_W-1:0]  br;
	logic [K_W-1:0]   coef;
	logic [BR_W+K_W-1:0] prod;

	assign ver   = hdr[20:19];
	assign layer = hdr[18:17];
	assign bri   = hdr[15:12];
	assign sri   = hdr[11:10];
	assign li    = 2'd3 - layer;
	assign vg    = (ver != VER_MPEG1);
	assign sr    = rate_lookup(ver, sri);
	assign br    = kbps_lookup(vg, li, bri);

	always_comb begin
		if (li == LI_ONE) begin
			coef = K_LAYER1;
		end else if (vg && li == LI_THREE) begin
			coef = K_HALF;
		end else begin
			coef = K_FULL;
		end
	end

	assign prod = br * coef;

	always_comb begin
		info.ok = (hdr[31:24] == SYNC_BYTE) && (hdr[23:21] == SYNC_TOP)
			&& (ver != VER_RSVD) && (layer != LAYER_RSVD)
			&& (bri != BRI_FREE) && (bri != BRI_BAD) && (sri != SRI_RSVD)
			&& (sr != '0) && (br != '0);
		info.sample_rate   = sr;
		info.channel_count = (hdr[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
		info.bitrate       = br;
		if (li == LI_ONE) begin
			info.spf = SPF_W'(384);
		end else if (vg && li == LI_THREE) begin
			info.spf = SPF_W'(576);
		end else begin
			info.spf = SPF_W'(1152);
		end
		info.pad    = hdr[9];
		info.layer1 = (li == LI_ONE);
		info.numer  = prod[NUM_W-1:0];
	end

endmodule

FILE: src/mahs_divider.sv
// Restoring divider, one quotient bit per cycle, for the frame-length division.
// Depends on mahs_pkg for operand widths.
module mahs_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mahs_pkg::NUM_W-1:0]  numer,
	input  logic [mahs_pkg::SR_W-1:0]   denom,
	output logic                        done,
	output logic [mahs_pkg::NUM_W-1:0]  quot
);
	import mahs_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SR_W-1:0]  rem_q;
	logic [SR_W-1:0]  den_q;
	logic [NUM_W-1:0] quo_q;
	logic [SR_W:0]    trial;
	logic [SR_W:0]    diff;
	logic             ge;

	// The dividend shifts out of the top of quo_q while quotient bits shift in.
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= denom;
			quo_q <= numer;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SR_W-1:0] : trial[SR_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

FILE: dv/tb_mpeg_audio_header_scanner_core.sv
`timescale 1ns / 1ps
// Testbench for mpeg_audio_header_scanner_core: streams byte buffers through the
// byte channel and checks every result item against a predictor of the scanner.
// Depends on mahs_pkg, mahs_if and the core with its submodules.
module tb_mpeg_audio_header_scanner_core;

	localparam int LIMIT        = 200000;
	localparam int RANDOM_BYTES = 840;
	localparam int QUIET_BYTES  = 150;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 40;
	localparam int IDLE_PCT     = 12;

	typedef struct packed {
		logic        found;
		logic [15:0] rate;
		logic [1:0]  chans;
		logic [8:0]  kbps;
		logic [10:0] spf;
		logic [11:0] len;
	} frame_info_t;

	localparam bit [0:2][15:0] RATE_M1  = {16'd44100, 16'd48000, 16'd32000};
	localparam bit [0:2][15:0] RATE_M2  = {16'd22050, 16'd24000, 16'd16000};
	localparam bit [0:2][15:0] RATE_M25 = {16'd11025, 16'd12000, 16'd8000};

	localparam bit [0:15][8:0] BR_M1_L1 = {9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160,
		9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
	localparam bit [0:15][8:0] BR_M1_L2 = {9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
		9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
	localparam bit [0:15][8:0] BR_M1_L3 = {9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
		9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
	localparam bit [0:15][8:0] BR_LSF_L1 = {9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
		9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
	localparam bit [0:15][8:0] BR_LSF_L23 = {9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40,
		9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

	logic clk;
	logic arst_n;

	mahs_byte_if   byte_ch ();
	mahs_result_if result_ch ();

	mpeg_audio_header_scanner_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.result_ch (result_ch)
	);

	// Scanner state as the predictor sees it.
	bit [23:0] scan_window;
	bit [1:0]  scan_count;
	bit        scan_locked;

	frame_info_t expected_frames[$];
	bit [7:0]    pending_bytes[$];

	int  mismatches;
	int  cycles;
	int  bytes_sent;
	int  bytes_scanned;
	int  buffers_sent;
	int  headers_found;
	int  empty_buffers;
	bit  quiet;
	bit  hold_ask;
	int  hold_left;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic bit decode_frame(input bit [31:0] w, output frame_info_t info);
		bit [1:0]    ver;
		bit [1:0]    layer;
		bit [1:0]    sri;
		bit [1:0]    li;
		bit [1:0]    mode;
		bit [3:0]    bri;
		bit          pad;
		bit          lsf;
		int unsigned rate;
		int unsigned kbps;
		int unsigned len;
		info = '0;
		if (w[31:24] != mahs_pkg::SYNC_BYTE || w[23:21] != mahs_pkg::SYNC_TOP)
			return 1'b0;
		ver = w[20:19];
		layer = w[18:17];
		bri = w[15:12];
		sri = w[11:10];
		pad = w[9];
		mode = w[7:6];
		if (ver == mahs_pkg::VER_RSVD || layer == mahs_pkg::LAYER_RSVD ||
				bri == mahs_pkg::BRI_FREE || bri == mahs_pkg::BRI_BAD ||
				sri == mahs_pkg::SRI_RSVD)
			return 1'b0;
		li = 2'd3 - layer;
		lsf = (ver != mahs_pkg::VER_MPEG1);
		case (ver)
			mahs_pkg::VER_MPEG1: rate = RATE_M1[sri];
			mahs_pkg::VER_MPEG2: rate = RATE_M2[sri];
			default:             rate = RATE_M25[sri];
		endcase
		if (!lsf) begin
			case (li)
				mahs_pkg::LI_ONE: kbps = BR_M1_L1[bri];
				mahs_pkg::LI_TWO: kbps = BR_M1_L2[bri];
				default:          kbps = BR_M1_L3[bri];
			endcase
		end else begin
			kbps = (li == mahs_pkg::LI_ONE) ? BR_LSF_L1[bri] : BR_LSF_L23[bri];
		end
		// Layer I counts four-byte slots; Layer III at the low rates uses half frames.
		if (li == mahs_pkg::LI_ONE)
			len = (12 * kbps * 1000 / rate + pad) * 4;
		else if (lsf && li == mahs_pkg::LI_THREE)
			len = 72 * kbps * 1000 / rate + pad;
		else
			len = 144 * kbps * 1000 / rate + pad;
		info.found = 1'b1;
		info.rate = rate[15:0];
		info.chans = (mode == mahs_pkg::MODE_MONO) ? 2'd1 : 2'd2;
		info.kbps = kbps[8:0];
		if (li == mahs_pkg::LI_ONE)
			info.spf = 11'd384;
		else if (lsf && li == mahs_pkg::LI_THREE)
			info.spf = 11'd576;
		else
			info.spf = 11'd1152;
		info.len = len[11:0];
		return 1'b1;
	endfunction

	task automatic clear_scan();
		scan_window = '0;
		scan_count = '0;
		scan_locked = 1'b0;
	endtask

	task automatic scan_predict(input bit [7:0] b, input bit last);
		frame_info_t info;
		bit          got;
		info = '0;
		got = 1'b0;
		if (scan_locked) begin
			if (last)
				clear_scan();
			return;
		end
		bytes_scanned++;
		if (scan_count == 2'd3)
			got = decode_frame({scan_window, b}, info);
		if (got)
			scan_locked = 1'b1;
		scan_window = {scan_window[15:0], b};
		if (scan_count != 2'd3)
			scan_count++;
		if (last) begin
			// With no header found, info is still all zero: the not-found item.
			got = 1'b1;
			clear_scan();
		end
		if (got) begin
			expected_frames.push_back(info);
			if (info.found)
				headers_found++;
			else
				empty_buffers++;
		end
	endtask

	function automatic string frame_text(input frame_info_t f);
		return $sformatf("found=%0d rate=%0d ch=%0d kbps=%0d spf=%0d len=%0d",
			f.found, f.rate, f.chans, f.kbps, f.spf, f.len);
	endfunction

	always @(posedge clk) begin : check_results
		frame_info_t seen;
		frame_info_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			seen.found = result_ch.found;
			seen.rate = result_ch.sample_rate;
			seen.chans = result_ch.channel_count;
			seen.kbps = result_ch.bitrate_kbps;
			seen.spf = result_ch.samples_per_frame;
			seen.len = result_ch.frame_length_bytes;
			if (expected_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing expected: %s", $realtime,
						frame_text(seen));
			end else begin
				want = expected_frames.pop_front();
				if (seen !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: result mismatch", $realtime);
						$display("  expected %s", frame_text(want));
						$display("  actual   %s", frame_text(seen));
					end
				end
			end
		end
	end

	// Receiver side; a requested hold keeps ready low for a long stretch.
	always @(negedge clk) begin
		if (hold_ask) begin
			hold_ask = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_frames.size());
			$display("mpeg_audio_header_scanner_core test failed");
			$finish;
		end
	end

	// Entered and left at a falling edge; valid stays high into the next item.
	task automatic send_byte(input bit [7:0] b, input bit last);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.last_byte <= last;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		scan_predict(b, last);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_buffer();
		for (int i = 0; i < pending_bytes.size(); i++)
			send_byte(pending_bytes[i], i == pending_bytes.size() - 1);
		pending_bytes.delete();
		buffers_sent++;
	endtask

	task automatic wait_drained();
		byte_ch.valid <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic push_header(input bit [31:0] h);
		pending_bytes.push_back(h[31:24]);
		pending_bytes.push_back(h[23:16]);
		pending_bytes.push_back(h[15:8]);
		pending_bytes.push_back(h[7:0]);
	endtask

	// Noise leans toward sync bytes so that false starts are common.
	task automatic push_noise(input int n);
		for (int i = 0; i < n; i++)
			pending_bytes.push_back(($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(255)));
	endtask

	function automatic bit [31:0] good_header();
		bit [1:0] ver;
		case ($urandom_range(2))
			0:       ver = mahs_pkg::VER_MPEG25;
			1:       ver = mahs_pkg::VER_MPEG2;
			default: ver = mahs_pkg::VER_MPEG1;
		endcase
		return {mahs_pkg::SYNC_BYTE, mahs_pkg::SYNC_TOP, ver, 2'($urandom_range(3, 1)),
			1'($urandom_range(1)), 4'($urandom_range(14, 1)), 2'($urandom_range(2)),
			2'($urandom_range(3)), 8'($urandom_range(255))};
	endfunction

	function automatic bit [31:0] bad_header();
		bit [31:0] h;
		h = good_header();
		case ($urandom_range(5))
			0:       h[20:19] = mahs_pkg::VER_RSVD;
			1:       h[18:17] = mahs_pkg::LAYER_RSVD;
			2:       h[15:12] = mahs_pkg::BRI_FREE;
			3:       h[15:12] = mahs_pkg::BRI_BAD;
			4:       h[11:10] = mahs_pkg::SRI_RSVD;
			default: h[23:21] = 3'($urandom_range(6));
		endcase
		return h;
	endfunction

	task automatic test_short_buffers();
		pending_bytes.push_back(8'h00);
		send_buffer();
		pending_bytes.push_back(8'hFF);
		pending_bytes.push_back(8'hFB);
		pending_bytes.push_back(8'h90);
		send_buffer();
	endtask

	task automatic test_header_on_last();
		push_header(32'hFFFB90C4);
		send_buffer();
	endtask

	// MPEG-2 Layer III header followed by bytes that must be ignored.
	task automatic test_ignored_tail();
		push_header(32'hFFF3E440);
		pending_bytes.push_back(8'h00);
		pending_bytes.push_back(8'hFF);
		send_buffer();
	endtask

	task automatic test_field_extremes();
		push_header(32'hFFFFE200);
		send_buffer();
		push_header(32'hFFE4EAC0);
		send_buffer();
		push_header(32'hFFE21400);
		send_buffer();
	endtask

	task automatic test_rejected_header();
		push_header(32'hFFFBF000);
		send_buffer();
	endtask

	task automatic test_receiver_hold();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		hold_ask = 1'b1;
		@(negedge clk);
		push_header(good_header());
		push_noise(12);
		send_buffer();
		push_header(good_header());
		push_noise(2);
		send_buffer();
		push_noise(5);
		send_buffer();
		wait_drained();
	endtask

	task automatic random_buffer();
		int kind;
		kind = $urandom_range(99);
		if (kind < 65) begin
			push_noise($urandom_range(6));
			push_header(good_header());
			push_noise($urandom_range(3));
		end else if (kind < 80) begin
			push_noise($urandom_range(3));
			push_header(bad_header());
			if ($urandom_range(1))
				push_header(good_header());
			push_noise($urandom_range(2));
		end else begin
			push_noise($urandom_range(10, 1));
		end
		send_buffer();
	endtask

	task automatic test_random_buffers();
		int  first;
		bit  paused;
		first = bytes_sent;
		paused = 1'b0;
		quiet = 1'b1;
		while (bytes_sent - first < RANDOM_BYTES) begin
			if (bytes_sent - first >= QUIET_BYTES)
				quiet = 1'b0;
			if (!paused && bytes_sent - first >= RANDOM_BYTES / 2) begin
				paused = 1'b1;
				wait_drained();
			end
			random_buffer();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.last_byte = 1'b0;
		result_ch.ready = 1'b0;
		quiet = 1'b0;
		hold_ask = 1'b0;
		hold_left = 0;
		clear_scan();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_short_buffers();
		test_header_on_last();
		test_ignored_tail();
		test_field_extremes();
		test_rejected_header();
		wait_drained();
		test_receiver_hold();
		test_random_buffers();

		byte_ch.valid <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d buffers, %0d bytes (%0d scanned before a header or end).",
			buffers_sent, bytes_sent, bytes_scanned);
		$display("Checked %0d decoded headers and %0d buffers with no header, %0d mismatches.",
			headers_found, empty_buffers, mismatches);
		if (mismatches == 0)
			$display("mpeg_audio_header_scanner_core test passed");
		else
			$display("mpeg_audio_header_scanner_core test failed");
		$finish;
	end

endmodule
